FILE: rtl/iip_pkg.sv
// Shared types, character codes and precedence helpers for the infix to postfix converter.
package iip_pkg;

   localparam logic [7:0] CH_END   = 8'h24;  // '$'
   localparam logic [7:0] CH_OPEN  = 8'h28;  // '('
   localparam logic [7:0] CH_CLOSE = 8'h29;  // ')'
   localparam logic [7:0] CH_MOD   = 8'h25;  // '%'
   localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
   localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
   localparam logic [7:0] CH_MUL   = 8'h2A;  // '*'
   localparam logic [7:0] CH_DIV   = 8'h2F;  // '/'

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_UNMATCHED = 2'd1,
      STATUS_OVERFLOW  = 2'd2
   } status_type;

   // Shift command applied to every cell of the stack in the same cycle.
   typedef struct packed {
      logic push;
      logic pop;
   } stk_op_type;

   function automatic logic is_op(input logic [7:0] c);
      return (c == CH_OPEN) || (c == CH_CLOSE) || (c == CH_PLUS) || (c == CH_MINUS) ||
             (c == CH_MUL) || (c == CH_DIV) || (c == CH_MOD) || (c == CH_END);
   endfunction

   // Precedence offset by one so that the open parenthesis sits at zero.
   function automatic logic [1:0] prec_of(input logic [7:0] c);
      logic [1:0] p;
      p = 2'd0;
      if ((c == CH_END) || (c == CH_CLOSE)) begin
         p = 2'd1;
      end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
         p = 2'd2;
      end else if ((c == CH_MUL) || (c == CH_DIV) || (c == CH_MOD)) begin
         p = 2'd3;
      end
      return p;
   endfunction

endpackage

FILE: rtl/iip_channels.sv
// Valid/ready channel interfaces for the converter's request and response sides.
interface iip_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       expr_end;

   modport source (output valid, output char_in, output expr_end, input ready);
   modport sink (input valid, input char_in, input expr_end, output ready);
endinterface

interface iip_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic [1:0] status;
   logic       out_last;

   modport source (output valid, output out_char, output status, output out_last, input ready);
   modport sink (input valid, input out_char, input status, input out_last, output ready);
endinterface

FILE: rtl/iip_cell.sv
// One entry of the operator stack; shifts toward the bottom on push and toward the top on pop.
module iip_cell (
   input  logic                clock,
   input  iip_pkg::stk_op_type op,
   input  logic [7:0]          from_above,
   input  logic [7:0]          from_below,
   output logic [7:0]          data
);
   import iip_pkg::*;

   logic [7:0] data_ff;
   logic [7:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (op.push) begin
         data_in = from_above;
      end else if (op.pop) begin
         data_in = from_below;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
endmodule

FILE: rtl/iip_stack.sv
// Operator stack built as a chain of cells with the top entry in cell zero.
module iip_stack #(
   parameter int DEPTH = 32
) (
   input  logic                clock,
   input  iip_pkg::stk_op_type op,
   input  logic [7:0]          push_data,
   output logic [7:0]          top
);
   import iip_pkg::*;

   logic [7:0] cell_data [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [7:0] above;
      logic [7:0] below;
      if (i == 0) begin : g_first
         assign above = push_data;
      end else begin : g_mid_above
         assign above = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign below = 8'h00;
      end else begin : g_mid_below
         assign below = cell_data[i+1];
      end
      iip_cell u_cell (
         .clock      (clock),
         .op         (op),
         .from_above (above),
         .from_below (below),
         .data       (cell_data[i])
      );
   end

   assign top = cell_data[0];
endmodule

FILE: rtl/infix_to_postfix_converter_unit.sv
// Top level of the shunting-yard infix to postfix converter.
//
//   channel   direction  payload                          accepted when
//   req_chan  in         char_in[7:0], expr_end           valid && ready
//   rsp_chan  out        out_char[7:0], status[1:0], last valid && ready
//
// An operand or a pushed operator is accepted in ST_IDLE and then processed in ST_CHAR.
// Every stack pop is a step of its own, and a transaction flagged with expr_end is
// followed by the end marker, handled as an operator, and a drain of each remaining entry. The
// stack is a chain of cells that shift together, so only one push or pop happens per
// cycle. Reset is synchronous and empties the stack by clearing its entry count; the
// cell contents are left as they are. A stalled response register holds the block
// wherever a result must be produced; pure pushes proceed regardless.
module infix_to_postfix_converter_unit #(
   parameter int STACK_DEPTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   iip_req_if.sink   req_chan,
   iip_rsp_if.source rsp_chan
);
   import iip_pkg::*;

   localparam int CW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHAR,
      ST_DRAIN
   } state_type;

   state_type  state_ff;
   logic [7:0] cur_ff;
   logic       last_ff;
   logic       end_phase_ff;
   logic [CW-1:0] count_ff;

   logic       rsp_valid_ff;
   logic [7:0] rsp_char_ff;
   status_type rsp_status_ff;
   logic       rsp_last_ff;

   logic [7:0] top;
   stk_op_type stk_op;

   logic       need_emit;
   logic [7:0] emit_char;
   status_type emit_status;
   logic       emit_last;
   logic       want_push;
   logic       want_pop;
   logic       step_done;
   logic       emit_ok;
   logic       go;
   logic       full;
   logic       empty;

   assign full    = count_ff >= CW'(STACK_DEPTH);
   assign empty   = count_ff == '0;
   assign emit_ok = !rsp_valid_ff || rsp_chan.ready;

   // Decide this cycle's single stack action and whether it produces a result.
   always_comb begin
      need_emit   = 1'b0;
      emit_char   = cur_ff;
      emit_status = STATUS_OK;
      emit_last   = 1'b0;
      want_push   = 1'b0;
      want_pop    = 1'b0;
      step_done   = 1'b0;
      case (state_ff)
         ST_CHAR: begin
            if (!is_op(cur_ff)) begin
               need_emit = 1'b1;
               step_done = 1'b1;
            end else if (cur_ff == CH_OPEN) begin
               if (full) begin
                  need_emit   = 1'b1;
                  emit_status = STATUS_OVERFLOW;
               end else begin
                  want_push = 1'b1;
               end
               step_done = 1'b1;
            end else if (cur_ff == CH_CLOSE) begin
               if (!empty && (top != CH_OPEN)) begin
                  need_emit = 1'b1;
                  emit_char = top;
                  want_pop  = 1'b1;
               end else if (empty) begin
                  // A close parenthesis with nothing left to match is reported and dropped.
                  need_emit   = 1'b1;
                  emit_status = STATUS_UNMATCHED;
                  step_done   = 1'b1;
               end else begin
                  // The matching open parenthesis is discarded without output.
                  want_pop  = 1'b1;
                  step_done = 1'b1;
               end
            end else begin
               if (!empty && (prec_of(cur_ff) <= prec_of(top))) begin
                  need_emit = 1'b1;
                  emit_char = top;
                  want_pop  = 1'b1;
               end else begin
                  if (full) begin
                     need_emit   = 1'b1;
                     emit_status = STATUS_OVERFLOW;
                  end else begin
                     want_push = 1'b1;
                  end
                  step_done = 1'b1;
               end
            end
         end
         ST_DRAIN: begin
            if (!empty) begin
               need_emit = 1'b1;
               emit_char = top;
               want_pop  = 1'b1;
               emit_last = count_ff == CW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   assign go          = !need_emit || emit_ok;
   assign stk_op.push = want_push && go;
   assign stk_op.pop  = want_pop && go;

   iip_stack #(
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock     (clock),
      .op        (stk_op),
      .push_data (cur_ff),
      .top       (top)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         end_phase_ff <= 1'b0;
      end else begin
         if (need_emit && go) begin
            rsp_valid_ff  <= 1'b1;
            rsp_char_ff   <= emit_char;
            rsp_status_ff <= emit_status;
            rsp_last_ff   <= emit_last;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (stk_op.push) begin
            count_ff <= count_ff + CW'(1);
         end else if (stk_op.pop) begin
            count_ff <= count_ff - CW'(1);
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_chan.valid) begin
                  cur_ff       <= req_chan.char_in;
                  last_ff      <= req_chan.expr_end;
                  end_phase_ff <= 1'b0;
                  state_ff     <= ST_CHAR;
               end
            end
            ST_CHAR: begin
               if (go && step_done) begin
                  if (end_phase_ff) begin
                     state_ff <= ST_DRAIN;
                  end else if (last_ff) begin
                     // The end marker follows the last character as an operator of its own.
                     cur_ff       <= CH_END;
                     end_phase_ff <= 1'b1;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_DRAIN: begin
               if (empty) begin
                  state_ff <= ST_IDLE;
               end else if (go && (count_ff == CW'(1))) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_chan.ready    = state_ff == ST_IDLE;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_char = rsp_char_ff;
   assign rsp_chan.status   = rsp_status_ff;
   assign rsp_chan.out_last = rsp_last_ff;
endmodule
